// ===== design/ocfe_pkg.sv =====
// ============================================================================
// ocfe_pkg
// Shared constants for the overlapped channel frame energy core: default
// sizes, field widths, register defaults, register indexes and pooling method codes.
// ============================================================================
package ocfe_pkg;

  // Default sizes
  localparam int OCFE_MAX_FRAME_LENGTH = 256;
  localparam int OCFE_MAX_CHANNELS     = 64;
  localparam int OCFE_MAX_OVERLAP      = 4;
  localparam int OCFE_SAMPLE_BITS      = 16;

  // Fixed field widths
  localparam int CFG_W    = 9;   // widest register
  localparam int FLEN_W   = 9;
  localparam int HOP_W    = 9;
  localparam int CCNT_W   = 7;
  localparam int METH_W   = 2;
  localparam int VAL_W    = 40;  // pooled value
  localparam int CHOUT_W  = 6;   // channel field
  localparam int FNUM_W   = 32;  // frame number
  localparam int CIDX_W   = 2;   // register index

  // Register defaults
  localparam logic [FLEN_W-1:0] FLEN_RESET = 9'd256;
  localparam logic [HOP_W-1:0]  HOP_RESET  = 9'd80;
  localparam logic [CCNT_W-1:0] CCNT_RESET = 7'd64;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_FRAME_LENGTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HOP           = 2'd1;
  localparam logic [CIDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_METHOD        = 2'd3;

  // Pooling methods (the unused code pools as sum of squares)
  localparam logic [METH_W-1:0] METHOD_MAX_SQ  = 2'd0;
  localparam logic [METH_W-1:0] METHOD_SUM_MAG = 2'd1;
  localparam logic [METH_W-1:0] METHOD_SUM_SQ  = 2'd2;

endpackage

// ===== design/overlapped_channel_frame_energy_core.sv =====
// ============================================================================
// overlapped_channel_frame_energy_core
// Pools channel-major filterbank samples into overlapping output frames,
// per channel max of squares, sum of magnitudes or sum of squares.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid / in_stall    | sample
//  out     | output    | out_valid / out_stall  | pooled_value, channel,
//          |           |                        | last_channel, frame_number
//  cfg     | input     | cfg_write              | cfg_index, cfg_data
//
//  One sample transaction per cycle sustained while in_stall is low; a result
//  passes through accept/read, modify/write back and the result queue.
//  Accumulators live in one row-per-channel memory, one slot per bank; a
//  row written in one cycle is forwarded to a read of the same row in that cycle.
//  Reset clears all control state; accumulator rows hold garbage until a
//  bank's first input frame writes them, so no clearing pass is needed.
//  in_stall rises only when the four-entry result queue plus the item in
//  flight could overfill it, i.e. only after out_stall has held the queue back.
//
module overlapped_channel_frame_energy_core
  import ocfe_pkg::*;
#(
  parameter int MAX_FRAME_LENGTH = OCFE_MAX_FRAME_LENGTH,
  parameter int MAX_CHANNELS     = OCFE_MAX_CHANNELS,
  parameter int MAX_OVERLAP      = OCFE_MAX_OVERLAP,
  parameter int SAMPLE_BITS      = OCFE_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [CIDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VAL_W-1:0]              pooled_value,
  output logic [CHOUT_W-1:0]            channel,
  output logic                          last_channel,
  output logic [FNUM_W-1:0]             frame_number
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int LEN_W  = $clog2(MAX_FRAME_LENGTH + 1);
  localparam int PW     = $clog2(MAX_FRAME_LENGTH);
  localparam int CMP_W  = PW + 1;
  localparam int EH_W   = (LEN_W > HOP_W) ? LEN_W : HOP_W;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BK_W   = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int ACC_W  = (SQ_W > VAL_W) ? SQ_W : VAL_W;
  localparam int ROW_W  = MAX_OVERLAP * ACC_W;
  localparam int QD     = 4;
  localparam int QP_W   = $clog2(QD);
  localparam int QC_W   = $clog2(QD + 1);

  // ceil(len / MAX_OVERLAP) through a multiply by a rounded-up reciprocal
  localparam int     NUM_W  = $clog2(MAX_FRAME_LENGTH + MAX_OVERLAP) + 1;
  localparam int     SHIFT  = NUM_W + $clog2(MAX_OVERLAP);
  localparam longint RECIP  = ((longint'(1) << SHIFT) + MAX_OVERLAP - 1) / MAX_OVERLAP;
  localparam int     RCP_W  = SHIFT + 1;
  localparam int     PROD_W = NUM_W + RCP_W;

  localparam logic [ACC_W:0] SUM_MAX = (ACC_W + 1)'({VAL_W{1'b1}});

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FLEN_W-1:0] frame_length;
  logic [HOP_W-1:0]  hop;
  logic [CCNT_W-1:0] channel_count;
  logic [METH_W-1:0] method;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= FLEN_RESET;
      hop           <= HOP_RESET;
      channel_count <= CCNT_RESET;
      method        <= METHOD_SUM_SQ;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_LENGTH:  frame_length  <= cfg_data[FLEN_W-1:0];
        REG_HOP:           hop           <= cfg_data[HOP_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CCNT_W-1:0];
        REG_METHOD:        method        <= cfg_data[METH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective frame length, hop and channel count
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]  len_eff;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  min_hop;
  logic [HOP_W-1:0]  hop_nz;
  logic [EH_W-1:0]   eff_hop;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CH_W-1:0]   last_idx;

  always_comb begin
    if (frame_length == '0)
      len_eff = LEN_W'(1);
    else if (32'(frame_length) > 32'(MAX_FRAME_LENGTH))
      len_eff = LEN_W'(MAX_FRAME_LENGTH);
    else
      len_eff = LEN_W'(frame_length);

    num     = NUM_W'(len_eff) + NUM_W'(MAX_OVERLAP - 1);
    prod    = PROD_W'(num) * PROD_W'(RECIP);
    min_hop = LEN_W'(prod >> SHIFT);

    hop_nz  = (hop == '0) ? HOP_W'(1) : hop;
    eff_hop = (EH_W'(hop_nz) < EH_W'(min_hop)) ? EH_W'(min_hop) : EH_W'(hop_nz);

    if (channel_count == '0)
      cnt_eff = CNT_W'(1);
    else if (32'(channel_count) > 32'(MAX_CHANNELS))
      cnt_eff = CNT_W'(MAX_CHANNELS);
    else
      cnt_eff = CNT_W'(channel_count);
    last_idx = CH_W'(cnt_eff - CNT_W'(1));
  end

  // --------------------------------------------------------------------------
  // Frame control state
  // --------------------------------------------------------------------------
  logic [MAX_OVERLAP-1:0] bank_active;
  logic [PW-1:0]          bank_progress     [MAX_OVERLAP];
  logic [FNUM_W-1:0]      bank_frame_number [MAX_OVERLAP];
  logic [CH_W-1:0]        channel_position;
  logic [EH_W-1:0]        hop_countdown;
  logic [FNUM_W-1:0]      next_frame_number;

  logic in_accept;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Stage 0: channel, bank start, per-bank flags
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]        ch;
  logic                   last_c;
  logic                   start;
  logic                   free_found;
  logic [BK_W-1:0]        free_idx;
  logic [MAX_OVERLAP-1:0] act_s;
  logic [PW-1:0]          prog_s      [MAX_OVERLAP];
  logic [FNUM_W-1:0]      fn_s        [MAX_OVERLAP];
  logic [MAX_OVERLAP-1:0] first_c;
  logic [MAX_OVERLAP-1:0] fin_c;
  logic [MAX_OVERLAP-1:0] active_next;
  logic [PW-1:0]          progress_next [MAX_OVERLAP];
  logic                   emit_c;
  logic [BK_W-1:0]        emit_idx;
  logic [EH_W-1:0]        hop_countdown_next;
  logic [SAMPLE_BITS-1:0] sample_u;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq;
  logic [ACC_W-1:0]       val_c;

  always_comb begin
    // channel position, clamped when the count shrank mid-frame
    if (channel_position >= last_idx) begin
      ch     = last_idx;
      last_c = 1'b1;
    end else begin
      ch     = channel_position;
      last_c = 1'b0;
    end

    start = (ch == '0) && (hop_countdown == '0);
    if (ch == '0)
      hop_countdown_next = start ? (eff_hop - EH_W'(1)) : (hop_countdown - EH_W'(1));
    else
      hop_countdown_next = hop_countdown;

    // lowest free bank
    free_found = 1'b0;
    free_idx   = '0;
    for (int b = 0; b < MAX_OVERLAP; b++) begin
      if (!bank_active[b] && !free_found) begin
        free_found = 1'b1;
        free_idx   = BK_W'(b);
      end
    end

    // bank state with the new frame folded in
    act_s = bank_active;
    for (int b = 0; b < MAX_OVERLAP; b++) begin
      prog_s[b] = bank_progress[b];
      fn_s[b]   = bank_frame_number[b];
    end
    if (start && free_found) begin
      act_s[free_idx]  = 1'b1;
      prog_s[free_idx] = '0;
      fn_s[free_idx]   = next_frame_number;
    end

    // per-bank flags, lowest finishing bank emits
    emit_c   = 1'b0;
    emit_idx = '0;
    for (int b = 0; b < MAX_OVERLAP; b++) begin
      first_c[b] = (prog_s[b] == '0);
      fin_c[b]   = (CMP_W'(prog_s[b]) + CMP_W'(1)) >= CMP_W'(len_eff);
      if (act_s[b] && fin_c[b] && !emit_c) begin
        emit_c   = 1'b1;
        emit_idx = BK_W'(b);
      end
      active_next[b]   = act_s[b] && !(fin_c[b] && last_c);
      progress_next[b] = (last_c && active_next[b]) ? (prog_s[b] + PW'(1)) : prog_s[b];
    end

    // magnitude and square of the sample
    sample_u = $unsigned(sample);
    mag      = sample_u[SAMPLE_BITS-1] ? (~sample_u + SAMPLE_BITS'(1)) : sample_u;
    sq       = SQ_W'(mag) * SQ_W'(mag);
    val_c    = (method == METHOD_SUM_MAG) ? ACC_W'(mag) : ACC_W'(sq);
  end

  // control state update
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_active       <= '0;
      channel_position  <= '0;
      hop_countdown     <= '0;
      next_frame_number <= '0;
      for (int b = 0; b < MAX_OVERLAP; b++) begin
        bank_progress[b]     <= '0;
        bank_frame_number[b] <= '0;
      end
    end else if (in_accept) begin
      bank_active      <= active_next;
      channel_position <= last_c ? '0 : (ch + CH_W'(1));
      hop_countdown    <= hop_countdown_next;
      if (start)
        next_frame_number <= next_frame_number + FNUM_W'(1);
      for (int b = 0; b < MAX_OVERLAP; b++) begin
        bank_progress[b]     <= progress_next[b];
        bank_frame_number[b] <= fn_s[b];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers
  // --------------------------------------------------------------------------
  logic                   s1_valid;
  logic [CH_W-1:0]        s1_ch;
  logic                   s1_last;
  logic [MAX_OVERLAP-1:0] s1_en;
  logic [MAX_OVERLAP-1:0] s1_first;
  logic                   s1_emit;
  logic [BK_W-1:0]        s1_bank;
  logic [FNUM_W-1:0]      s1_fn;
  logic                   s1_max;
  logic [ACC_W-1:0]       s1_val;

  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else
      s1_valid <= in_accept;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ch    <= ch;
      s1_last  <= last_c;
      s1_en    <= act_s;
      s1_first <= first_c;
      s1_emit  <= emit_c;
      s1_bank  <= emit_idx;
      s1_fn    <= fn_s[emit_idx];
      s1_max   <= (method == METHOD_MAX_SQ);
      s1_val   <= val_c;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulator memory: one row per channel, one slot per bank
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] acc_mem [MAX_CHANNELS];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] new_row;

  always_ff @(posedge clk) begin
    if (s1_valid)
      acc_mem[s1_ch] <= new_row;
    if (in_accept)
      rd_row <= acc_mem[ch];
  end

  // last written row, forwarded to a read of the same row issued in the write's cycle
  logic             fwd_valid;
  logic [CH_W-1:0]  fwd_addr;
  logic [ROW_W-1:0] fwd_row;

  always_ff @(posedge clk) begin
    if (rst)
      fwd_valid <= 1'b0;
    else if (s1_valid)
      fwd_valid <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_addr <= s1_ch;
      fwd_row  <= new_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: read-modify-write of every active bank's slot
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] old_row;
  logic [ACC_W-1:0] old_acc;
  logic [ACC_W-1:0] new_acc;
  logic [ACC_W:0]   sum;
  logic [VAL_W-1:0] res_val;

  always_comb begin
    old_row = (fwd_valid && (fwd_addr == s1_ch)) ? fwd_row : rd_row;
    new_row = old_row;
    res_val = '0;
    for (int b = 0; b < MAX_OVERLAP; b++) begin
      old_acc = old_row[b*ACC_W +: ACC_W];
      sum     = (ACC_W + 1)'(old_acc) + (ACC_W + 1)'(s1_val);
      if (!s1_en[b])
        new_acc = old_acc;
      else if (s1_first[b])
        new_acc = s1_val;
      else if (s1_max)
        new_acc = (s1_val > old_acc) ? s1_val : old_acc;
      else if (sum > SUM_MAX)
        new_acc = SUM_MAX[ACC_W-1:0];
      else
        new_acc = sum[ACC_W-1:0];
      new_row[b*ACC_W +: ACC_W] = new_acc;
      if (BK_W'(b) == s1_bank)
        res_val = new_acc[VAL_W-1:0];
    end
  end

  // channel field keeps the low six bits of the channel index
  logic [CH_W+CHOUT_W-1:0] s1_ch_ext;
  assign s1_ch_ext = (CH_W + CHOUT_W)'(s1_ch);

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0]   q_val  [QD];
  logic [CHOUT_W-1:0] q_ch   [QD];
  logic               q_last [QD];
  logic [FNUM_W-1:0]  q_fn   [QD];
  logic [QP_W-1:0]    q_head;
  logic [QP_W-1:0]    q_tail;
  logic [QC_W-1:0]    q_count;
  logic               q_push;
  logic               q_pop;

  assign q_push = s1_valid && s1_emit;
  assign q_pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      if (q_push)
        q_tail <= q_tail + QP_W'(1);
      if (q_pop)
        q_head <= q_head + QP_W'(1);
      case ({q_push, q_pop})
        2'b10:   q_count <= q_count + QC_W'(1);
        2'b01:   q_count <= q_count - QC_W'(1);
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_val[q_tail]  <= res_val;
      q_ch[q_tail]   <= s1_ch_ext[CHOUT_W-1:0];
      q_last[q_tail] <= s1_last;
      q_fn[q_tail]   <= s1_fn;
    end
  end

  // hold off input when the queue plus the item in flight could overfill it
  assign in_stall = ((QC_W + 1)'(q_count) + (QC_W + 1)'(s1_valid)) >= (QC_W + 1)'(QD);

  assign out_valid    = (q_count != '0);
  assign pooled_value = q_val[q_head];
  assign channel      = q_ch[q_head];
  assign last_channel = q_last[q_head];
  assign frame_number = q_fn[q_head];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QC_W'(QD))
    else $error("result queue overfilled");

  a_emit_bank_live: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit) |-> s1_en[s1_bank])
    else $error("result taken from an inactive bank");

  a_wrap_channel: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_c) |=> (channel_position == '0))
    else $error("channel position did not wrap after the last channel");

  a_start_number: assert property (@(posedge clk) disable iff (rst)
    (in_accept && start && free_found) |=>
      (bank_frame_number[$past(free_idx)] == $past(next_frame_number)))
    else $error("started bank lost its frame number");
`endif

endmodule

// ===== test/ocfe_energy_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ocfe_energy_checker
// Watches the register port and both channels of the frame energy core,
// keeps its own copy of the bank pooling state, and compares each result
// transaction field by field with the oldest pooled value still owed.
// ============================================================================
module ocfe_energy_checker
  import ocfe_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [CIDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [OCFE_SAMPLE_BITS-1:0] sample,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [VAL_W-1:0]                   pooled_value,
  input  logic [CHOUT_W-1:0]                 channel,
  input  logic                               last_channel,
  input  logic [FNUM_W-1:0]                  frame_number,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 result_count
);

  localparam int NBANK = OCFE_MAX_OVERLAP;
  localparam int NCHAN = OCFE_MAX_CHANNELS;
  localparam int SB    = OCFE_SAMPLE_BITS;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic               known;   // value built only from written entries
    logic [CHOUT_W-1:0] chan;
    logic               last_ch;
    logic [FNUM_W-1:0]  fnum;
  } pool_result_t;

  // register copies
  logic [FLEN_W-1:0] frame_length_r;
  logic [HOP_W-1:0]  hop_r;
  logic [CCNT_W-1:0] chan_count_r;
  logic [METH_W-1:0] method_r;

  // bank state
  logic [VAL_W-1:0]   acc_mem [NBANK][NCHAN];
  logic               acc_known [NBANK][NCHAN];  // entry written since reset
  logic               bank_busy [NBANK];
  logic [FLEN_W-1:0]  bank_done [NBANK];   // input frames pooled so far
  logic [FNUM_W-1:0]  bank_fnum [NBANK];
  logic [CHOUT_W-1:0] chan_pos;
  logic [HOP_W-1:0]   hop_left;
  logic [FNUM_W-1:0]  next_fnum;

  pool_result_t pool_q[$];
  pool_result_t oldest;

  // Pool one sample transaction into every active bank; queue the value of the
  // lowest bank that closes on this input frame.
  task automatic pool_sample(input logic signed [SB-1:0] s);
    int unsigned   len;
    int unsigned   cnt;
    int unsigned   step;
    int unsigned   min_step;
    logic [SB-1:0] mag;
    logic [VAL_W-1:0] sq;
    logic [VAL_W-1:0] v;
    logic [VAL_W:0]   sum;
    logic [CHOUT_W-1:0] ch;
    logic          is_last;
    logic          emitted;
    logic          placed;
    pool_result_t  r;

    // effective sizes
    len = frame_length_r;
    if (len < 1) len = 1;
    if (len > OCFE_MAX_FRAME_LENGTH) len = OCFE_MAX_FRAME_LENGTH;
    cnt = chan_count_r;
    if (cnt < 1) cnt = 1;
    if (cnt > NCHAN) cnt = NCHAN;
    step = (hop_r == '0) ? 1 : hop_r;
    min_step = (len + NBANK - 1) / NBANK;
    if (step < min_step) step = min_step;

    mag = s[SB-1] ? (~s + 1'b1) : s;
    sq  = VAL_W'(mag) * VAL_W'(mag);

    // a position left past a shrunken count is the last channel
    if (chan_pos >= cnt - 1) begin
      ch = CHOUT_W'(cnt - 1);
      is_last = 1'b1;
    end else begin
      ch = chan_pos;
      is_last = 1'b0;
    end

    // bank start at channel 0; with no free bank the frame number is lost
    if (ch == '0) begin
      if (hop_left == '0) begin
        placed = 1'b0;
        for (int b = 0; b < NBANK; b++) begin
          if (!placed && !bank_busy[b]) begin
            bank_busy[b] = 1'b1;
            bank_done[b] = '0;
            bank_fnum[b] = next_fnum;
            placed = 1'b1;
          end
        end
        next_fnum = next_fnum + 1'b1;
        hop_left  = HOP_W'(step - 1);
      end else begin
        hop_left = hop_left - 1'b1;
      end
    end

    emitted = 1'b0;
    v = (method_r == METHOD_SUM_MAG) ? VAL_W'(mag) : sq;
    for (int b = 0; b < NBANK; b++) begin
      if (bank_busy[b]) begin
        if (bank_done[b] == '0) begin
          acc_mem[b][ch]   = v;
          acc_known[b][ch] = 1'b1;
        end else if (method_r == METHOD_MAX_SQ) begin
          if (v > acc_mem[b][ch]) acc_mem[b][ch] = v;
        end else begin
          sum = acc_mem[b][ch] + v;
          acc_mem[b][ch] = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
        end
        // only the lowest closing bank reports, the rest retire quietly
        if (bank_done[b] + 1 >= len) begin
          if (!emitted) begin
            r.value   = acc_mem[b][ch];
            r.known   = acc_known[b][ch];
            r.chan    = ch;
            r.last_ch = is_last;
            r.fnum    = bank_fnum[b];
            pool_q.push_back(r);
            emitted = 1'b1;
          end
          if (is_last) bank_busy[b] = 1'b0;
        end
        if (is_last && bank_busy[b]) bank_done[b] = bank_done[b] + 1'b1;
      end
    end

    chan_pos = is_last ? '0 : ch + 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_length_r = FLEN_RESET;
      hop_r          = HOP_RESET;
      chan_count_r   = CCNT_RESET;
      method_r       = METHOD_SUM_SQ;
      for (int b = 0; b < NBANK; b++) begin
        bank_busy[b] = 1'b0;
        bank_done[b] = '0;
        bank_fnum[b] = '0;
        for (int c = 0; c < NCHAN; c++) begin
          acc_mem[b][c]   = '0;
          acc_known[b][c] = 1'b0;
        end
      end
      chan_pos     = '0;
      hop_left     = '0;
      next_fnum    = '0;
      pool_q.delete();
      fail_count   = 0;
      result_count = 0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_LENGTH:  frame_length_r = cfg_data[FLEN_W-1:0];
          REG_HOP:           hop_r          = cfg_data[HOP_W-1:0];
          REG_CHANNEL_COUNT: chan_count_r   = cfg_data[CCNT_W-1:0];
          REG_METHOD:        method_r       = cfg_data[METH_W-1:0];
          default: ;
        endcase
      end

      // sample transaction
      if (in_valid && !in_stall) pool_sample(sample);

      // result transaction; a value pooled from unwritten entries is not compared
      if (out_valid && !out_stall) begin
        result_count++;
        if (pool_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected pooled result: value %0d ch %0d last %0b frame %0d",
                     $time, pooled_value, channel, last_channel, frame_number);
          end
          fail_count++;
        end else begin
          oldest = pool_q.pop_front();
          if ((oldest.known && pooled_value !== oldest.value) ||
              channel !== oldest.chan ||
              last_channel !== oldest.last_ch || frame_number !== oldest.fnum) begin
            if (fail_count < 10) begin
              $display("%0t: pooled result mismatch: exp value %0d ch %0d last %0b frame %0d",
                       $time, oldest.value, oldest.chan, oldest.last_ch, oldest.fnum);
              $display("%0t:                         got value %0d ch %0d last %0b frame %0d",
                       $time, pooled_value, channel, last_channel, frame_number);
            end
            fail_count++;
          end
        end
      end
    end
    pending = pool_q.size();
  end

endmodule

// ===== test/tb_overlapped_channel_frame_energy_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_overlapped_channel_frame_energy_core
// Streams directed and random filterbank samples through the frame energy
// core under many register settings, with random idle cycles on both sides,
// a long result hold-off, and a checker that predicts every pooled result.
// ============================================================================
module tb_overlapped_channel_frame_energy_core;
  import ocfe_pkg::*;

  localparam int SB            = OCFE_SAMPLE_BITS;
  localparam int STREAM_ITEMS  = 900;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int IDLE_LIMIT    = 1000;

  // method code with no name of its own; pools as sum of squares
  localparam logic [METH_W-1:0] METHOD_SPARE = 2'd3;

  localparam logic signed [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] S_ONE  = 1;
  localparam logic signed [SB-1:0] S_NEG1 = '1;
  localparam logic signed [SB-1:0] S_ZERO = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic signed [SB-1:0] sample = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]   pooled_value;
  logic [CHOUT_W-1:0] channel;
  logic               last_channel;
  logic [FNUM_W-1:0]  frame_number;

  int fail_count;
  int pending;
  int result_count;
  int sent = 0;

  logic tx_steady    = 1'b0;
  logic rx_steady    = 1'b0;
  logic hold_off_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  overlapped_channel_frame_energy_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pooled_value (pooled_value),
    .channel      (channel),
    .last_channel (last_channel),
    .frame_number (frame_number)
  );

  ocfe_energy_checker u_energy_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pooled_value (pooled_value),
    .channel      (channel),
    .last_channel (last_channel),
    .frame_number (frame_number),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  // Write all four registers, one per cycle; only called with the core idle.
  task automatic configure(input logic [CFG_W-1:0] flen, input logic [CFG_W-1:0] hop_len,
                           input logic [CFG_W-1:0] chans, input logic [CFG_W-1:0] meth);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_LENGTH;
    cfg_data  <= flen;
    @(negedge clk);
    cfg_index <= REG_HOP;
    cfg_data  <= hop_len;
    @(negedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= chans;
    @(negedge clk);
    cfg_index <= REG_METHOD;
    cfg_data  <= meth;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One sample transaction after a random gap; holds until accepted.
  task automatic push_sample(input logic signed [SB-1:0] s);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Random samples, with the extremes mixed in.
  task automatic stream_random(input int count);
    logic signed [SB-1:0] s;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) begin
        s = ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
      end else begin
        s = SB'($urandom);
      end
      push_sample(s);
    end
  endtask

  // Stop sending and wait until every owed result has arrived, then settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stall before each transaction, one long hold-off.
  initial begin : receiver
    int n;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        n = rx_steady ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] flen;
    logic [CFG_W-1:0] hop_len;
    logic [CFG_W-1:0] chans;
    logic [CFG_W-1:0] meth;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // pairs of frames, hop of zero, max of squares over sample extremes
    configure(2, 0, 1, METHOD_MAX_SQ);
    push_sample(S_MIN);
    push_sample(S_ONE);
    push_sample(S_NEG1);
    push_sample(S_MAX);
    push_sample(S_ZERO);
    drain();

    // sum of magnitudes
    configure(2, 0, 1, METHOD_SUM_MAG);
    push_sample(S_MIN);
    push_sample(S_MAX);
    push_sample(S_NEG1);
    drain();

    // sum of squares over two channels
    configure(2, 1, 2, METHOD_SUM_SQ);
    push_sample(S_MIN);
    push_sample(S_MIN);
    push_sample(S_MAX);
    drain();

    // spare method code; hop of 1 raised to 2 by the frame length
    configure(5, 1, 1, METHOD_SPARE);
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample(S_ONE);
    push_sample(S_NEG1);
    push_sample(S_MIN);
    drain();

    // three channels, stop in the middle of an input frame
    configure(8, 1, 3, METHOD_SUM_SQ);
    push_sample(S_MAX);
    push_sample(S_MIN);
    drain();

    // one channel now: position past the count, all open banks close at once
    configure(1, 1, 1, METHOD_SUM_SQ);
    push_sample(S_NEG1);
    push_sample(S_MAX);
    drain();

    // three banks open, then a longer frame leaves no bank free
    configure(4, 1, 1, METHOD_SUM_MAG);
    push_sample(S_MIN);
    push_sample(S_MAX);
    push_sample(S_ONE);
    drain();
    configure(8, 1, 1, METHOD_SUM_MAG);
    push_sample(S_MIN);
    push_sample(S_NEG1);
    push_sample(S_MAX);
    drain();

    sent = 0;

    // receiver holds off while samples keep coming at full rate
    configure(1, 1, 4, METHOD_SUM_SQ);
    tx_steady    = 1'b1;
    hold_off_req = 1'b1;
    stream_random(40);
    drain();
    tx_steady = 1'b0;

    // longest frame (clamped from 511), hop raised to a quarter of it
    configure(511, 1, 1, METHOD_SUM_SQ);
    stream_random(280);
    drain();

    // widest channel count (clamped from 127), frame of one
    configure(1, 0, 127, METHOD_MAX_SQ);
    stream_random(140);
    drain();

    // random phases, mostly small sizes, settings changed mid-stream
    while (sent < STREAM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        flen    = ($urandom_range(0, 15) == 0) ? CFG_W'($urandom_range(0, 511))
                                               : CFG_W'($urandom_range(1, 8));
        hop_len = ($urandom_range(0, 15) == 0) ? CFG_W'($urandom_range(0, 511))
                                               : CFG_W'($urandom_range(0, 6));
        chans   = ($urandom_range(0, 15) == 0) ? CFG_W'($urandom_range(0, 127))
                                               : CFG_W'($urandom_range(1, 6));
        meth    = CFG_W'($urandom_range(0, 3));
        configure(flen, hop_len, chans, meth);
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      stream_random($urandom_range(8, 48));
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
